// ----- hdl/rwct_pkg.sv -----
// ----------------------------------------------------------------------------
// rwct_pkg
// Shared types, codes and widths of the textured wall column block.
// ----------------------------------------------------------------------------
package rwct_pkg;

  localparam int DEF_TEX_WIDTH    = 64;
  localparam int DEF_TEX_HEIGHT   = 64;
  localparam int DEF_NUM_TEXTURES = 4;
  localparam int DEF_MAX_ROWS     = 4096;

  localparam int COLOR_W   = 24;
  localparam int ROW_W     = 12;
  localparam int HGT_W     = 13;
  localparam int KIND_W    = 2;
  localparam int CFG_IDX_W = 2;

  // Slice height is at most 2^21-1; the divider numerator covers 256 << 16.
  localparam int SLICE_H_W = 21;
  localparam int DIV_NUM_W = 25;
  localparam int DIV_DEN_W = SLICE_H_W;

  localparam logic [SLICE_H_W-1:0] HEIGHT_SAT = '1;
  localparam logic [HGT_W-1:0] SCREEN_HEIGHT_RESET = 13'd480;

  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_START = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PIXEL = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CEILING_COLOR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FLOOR_COLOR   = 2'd2;

  typedef enum logic [1:0] {
    SRC_CEILING,
    SRC_TEXEL,
    SRC_FLOOR
  } pixel_src_t;

endpackage

// ----- hdl/rwct_ram.sv -----
// ----------------------------------------------------------------------------
// rwct_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rwct_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/rwct_div.sv -----
// ----------------------------------------------------------------------------
// rwct_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rwct_div
  import rwct_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DIV_NUM_W-1:0] numer,
  input  logic [DIV_DEN_W-1:0] denom,
  output logic                 done,
  output logic [DIV_NUM_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIV_NUM_W + 1);

  logic                 busy;
  logic [CNT_W-1:0]     count;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_DEN_W-1:0] den;
  logic [DIV_DEN_W:0]   trial;
  logic                 fits;

  assign trial = {rem, quotient[DIV_NUM_W-1]};
  assign fits  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        count    <= CNT_W'(DIV_NUM_W);
        rem      <= '0;
        den      <= denom;
        quotient <= numer;
      end else if (busy) begin
        // The numerator shifts out at the top while quotient bits enter below.
        rem      <= fits ? DIV_DEN_W'(trial - {1'b0, den}) : trial[DIV_DEN_W-1:0];
        quotient <= {quotient[DIV_NUM_W-2:0], fits};
        count    <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- hdl/raycast_wall_column_texturer.sv -----
// ----------------------------------------------------------------------------
// raycast_wall_column_texturer
// Textured wall column generator for a grid raycaster.
// ----------------------------------------------------------------------------
// Requests enter on in_valid/in_ready and carry a kind: a texture write, a
// column start or a pixel request. Only pixel requests produce a result on
// out_valid/out_ready (color, row, last_row), one row of the column per
// request, top row first; pixel requests after the last row give no result.
// Configuration is written through cfg_write, cfg_index and cfg_data; the
// user must write it only while the block is idle, as the block does not
// enforce this. For a pixel request the texel memory read is registered and
// the result register is loaded from it in ST_PIX. A column start runs
// through ST_COL, ST_DIVH, ST_SPLIT, ST_DIVS and ST_POS, with two passes of
// the shared 25-step bit-serial divider (slice height, then texture step);
// a zero wall distance skips the first pass, a zero slice height the second.
// Reset clears the column state, so pixel requests before any column give
// the floor color; texture memory contents are undefined until written.
// While a result waits on a stalled receiver no new request is taken.
// ----------------------------------------------------------------------------
module raycast_wall_column_texturer
  import rwct_pkg::*;
#(
  parameter int TEX_WIDTH    = DEF_TEX_WIDTH,
  parameter int TEX_HEIGHT   = DEF_TEX_HEIGHT,
  parameter int NUM_TEXTURES = DEF_NUM_TEXTURES,
  parameter int MAX_ROWS     = DEF_MAX_ROWS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [KIND_W-1:0]    kind,
  input  logic [1:0]           side,
  input  logic [11:0]          texel_address,
  input  logic [COLOR_W-1:0]   texel_value,
  input  logic [15:0]          wall_distance,
  input  logic signed [15:0]   dir_x,
  input  logic signed [15:0]   dir_y,
  input  logic [15:0]          eye_x,
  input  logic [15:0]          eye_y,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [COLOR_W-1:0]   color,
  output logic [ROW_W-1:0]     row,
  output logic                 last_row,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COLOR_W-1:0]   cfg_data
);

  localparam int TEXELS = TEX_WIDTH * TEX_HEIGHT;
  localparam int DEPTH  = NUM_TEXTURES * TEXELS;
  localparam int AW     = $clog2(DEPTH);
  localparam int CW     = $clog2(TEX_WIDTH);
  localparam int TRW    = $clog2(TEX_HEIGHT);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_COL   = 3'd1;
  localparam logic [2:0] ST_DIVH  = 3'd2;
  localparam logic [2:0] ST_SPLIT = 3'd3;
  localparam logic [2:0] ST_DIVS  = 3'd4;
  localparam logic [2:0] ST_POS   = 3'd5;
  localparam logic [2:0] ST_PIX   = 3'd6;

  logic [2:0] state;

  // Configuration registers
  logic [HGT_W-1:0]   screen_height;
  logic [COLOR_W-1:0] ceiling_color;
  logic [COLOR_W-1:0] floor_color;

  // Column state
  logic [1:0]          column_side;
  logic [CW-1:0]       texture_column;
  logic [ROW_W-1:0]    slice_start;
  logic [ROW_W-1:0]    slice_end;
  logic [ROW_W-1:0]    row_counter;
  logic [31:0]         texture_position;
  logic [31:0]         texture_step;
  logic                column_done;

  // Column setup registers
  logic [21:0]          su_frac;
  logic [1:0]           su_side;
  logic [15:0]          su_dist;
  logic                 su_flip;
  logic [SLICE_H_W-1:0] slice_h;
  logic [19:0]          su_off;

  // Pixel registers
  pixel_src_t       pix_src;
  logic [ROW_W-1:0] pix_row;
  logic             pix_last;

  logic               accept;
  logic [HGT_W-1:0]   hgt;
  logic [32:0]        hit_prod;
  logic [21:0]        hit_frac;
  logic [CW-1:0]      col_raw;
  logic [30:0]        col_prod;
  logic [19:0]        half;
  logic [ROW_W-1:0]   hh;
  logic [20:0]        end_sum;
  logic [TRW-1:0]     trow;
  logic [1:0]         tex_sel;
  logic [AW-1:0]      rd_addr;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [COLOR_W-1:0] rd_data;
  logic               last_now;

  logic                 div_start;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic                 div_done;
  logic [DIV_NUM_W-1:0] div_quo;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == ST_IDLE) && (!out_valid || out_ready);

  always_comb begin
    if (screen_height == '0) begin
      hgt = HGT_W'(1);
    end else if (screen_height > HGT_W'(MAX_ROWS)) begin
      hgt = HGT_W'(MAX_ROWS);
    end else begin
      hgt = screen_height;
    end
  end

  // Only the 22 fraction bits of the hit point matter.
  always_comb begin
    if (side[0] == 1'b0) begin
      hit_prod = $signed({1'b0, wall_distance}) * dir_y;
      hit_frac = 22'({eye_y[7:0], 14'b0}) + hit_prod[21:0];
    end else begin
      hit_prod = $signed({1'b0, wall_distance}) * dir_x;
      hit_frac = 22'({eye_x[7:0], 14'b0}) + hit_prod[21:0];
    end
  end

  assign col_prod = 31'(su_frac) * 31'(TEX_WIDTH);
  assign col_raw  = CW'(col_prod >> 22);

  assign half    = 20'(slice_h >> 1);
  assign hh      = ROW_W'(hgt >> 1);
  assign end_sum = 21'(hh) + 21'(half);

  // Texel row, clamped to the texture.
  always_comb begin
    if (texture_position[31:16] > 16'(TEX_HEIGHT - 1)) begin
      trow = TRW'(TEX_HEIGHT - 1);
    end else begin
      trow = TRW'(texture_position[31:16]);
    end
  end

  always_comb begin
    tex_sel = column_side;
    for (int i = 0; i < 3; i++) begin
      if (32'(tex_sel) >= 32'(NUM_TEXTURES)) begin
        tex_sel = 2'(32'(tex_sel) - 32'(NUM_TEXTURES));
      end
    end
  end

  assign rd_addr = AW'(32'(tex_sel) * 32'(TEXELS) + 32'(trow) * 32'(TEX_WIDTH)
                       + 32'(texture_column));
  assign wr_en   = accept && (kind == KIND_WRITE) && (32'(side) < 32'(NUM_TEXTURES))
                   && (32'(texel_address) < 32'(TEXELS));
  assign wr_addr = AW'(32'(side) * 32'(TEXELS) + 32'(texel_address));

  assign last_now = {1'b0, row_counter} >= hgt - 1'b1;

  always_comb begin
    div_start = 1'b0;
    div_num   = DIV_NUM_W'(32'(TEX_HEIGHT) << 16);
    div_den   = slice_h;
    if (state == ST_COL && su_dist != '0) begin
      div_start = 1'b1;
      div_num   = DIV_NUM_W'({hgt, 8'b0});
      div_den   = DIV_DEN_W'(su_dist);
    end else if (state == ST_SPLIT && slice_h != '0) begin
      div_start = 1'b1;
    end
  end

  rwct_ram #(
    .WIDTH(COLOR_W),
    .DEPTH(DEPTH)
  ) u_tex_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(texel_value),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  rwct_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .numer   (div_num),
    .denom   (div_den),
    .done    (div_done),
    .quotient(div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_height <= SCREEN_HEIGHT_RESET;
      ceiling_color <= '0;
      floor_color   <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SCREEN_HEIGHT: screen_height <= cfg_data[HGT_W-1:0];
        REG_CEILING_COLOR: ceiling_color <= cfg_data;
        REG_FLOOR_COLOR:   floor_color   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      out_valid        <= 1'b0;
      column_side      <= '0;
      texture_column   <= '0;
      slice_start      <= '0;
      slice_end        <= '0;
      row_counter      <= '0;
      texture_position <= '0;
      texture_step     <= '0;
      column_done      <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept && kind == KIND_START) begin
            su_frac <= hit_frac;
            su_side <= side;
            su_dist <= wall_distance;
            su_flip <= (side == 2'd0 && dir_x > 0) || (side == 2'd1 && dir_y < 0);
            state   <= ST_COL;
          end else if (accept && kind == KIND_PIXEL && !column_done) begin
            pix_row  <= row_counter;
            pix_last <= last_now;
            if (row_counter < slice_start) begin
              pix_src <= SRC_CEILING;
            end else if (row_counter < slice_end) begin
              pix_src          <= SRC_TEXEL;
              texture_position <= texture_position + texture_step;
            end else begin
              pix_src <= SRC_FLOOR;
            end
            if (last_now) begin
              column_done <= 1'b1;
            end else begin
              row_counter <= row_counter + 1'b1;
            end
            state <= ST_PIX;
          end
        end
        ST_COL: begin
          texture_column <= su_flip ? CW'(TEX_WIDTH - 1) - col_raw : col_raw;
          if (su_dist == '0) begin
            slice_h <= HEIGHT_SAT;
            state   <= ST_SPLIT;
          end else begin
            state <= ST_DIVH;
          end
        end
        ST_DIVH: begin
          if (div_done) begin
            slice_h <= div_quo[SLICE_H_W-1:0];
            state   <= ST_SPLIT;
          end
        end
        ST_SPLIT: begin
          slice_start <= (half > 20'(hh)) ? '0 : ROW_W'(20'(hh) - half);
          slice_end   <= (end_sum >= 21'(hgt)) ? ROW_W'(hgt - 1'b1) : ROW_W'(end_sum);
          su_off      <= (half > 20'(hh)) ? half - 20'(hh) : '0;
          column_side <= su_side;
          row_counter <= '0;
          column_done <= 1'b0;
          if (slice_h == '0) begin
            texture_step     <= '0;
            texture_position <= '0;
            state            <= ST_IDLE;
          end else begin
            state <= ST_DIVS;
          end
        end
        ST_DIVS: begin
          if (div_done) begin
            texture_step <= 32'(div_quo);
            state        <= ST_POS;
          end
        end
        ST_POS: begin
          texture_position <= 32'(52'(su_off) * 52'(texture_step));
          state            <= ST_IDLE;
        end
        ST_PIX: begin
          case (pix_src)
            SRC_CEILING: color <= ceiling_color;
            SRC_TEXEL:   color <= rd_data;
            default:     color <= floor_color;
          endcase
          row       <= pix_row;
          last_row  <= pix_last;
          out_valid <= 1'b1;
          state     <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_pix_loads_result: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PIX) |=> out_valid)
    else $error("pixel result was not loaded");

  a_pix_slot_free: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PIX) |-> !out_valid)
    else $error("pixel result would overwrite a pending result");

  a_slice_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (slice_start <= slice_end))
    else $error("slice start lies below slice end");

  a_div_idle_start: assert property (@(posedge clk) disable iff (rst)
    div_start |-> (state == ST_COL || state == ST_SPLIT))
    else $error("divider started outside column setup");
`endif

endmodule
